// File: sv/nps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Netpbm stream parser package
// Shared types, character codes and phase encoding for the PGM/PPM parser.
// ----------------------------------------------------------------------------
package nps_pkg;

  // Width of the header numbers and of the pixel counters.
  localparam int unsigned DIM_BITS = 16;
  // Width of one decimal step: value * 10 + digit.
  localparam int unsigned ACC_W    = DIM_BITS + 4;

  typedef logic [DIM_BITS-1:0] dim_t;
  typedef logic [ACC_W-1:0]    acc_t;

  localparam acc_t DIM_MAX   = acc_t'((64'd1 << DIM_BITS) - 64'd1);
  localparam acc_t SAMPLE_MAX = acc_t'(255);

  // Character codes.
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_SIX   = 8'h36;

  typedef enum logic [3:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_W_SKIP,
    PH_W_NUM,
    PH_H_SKIP,
    PH_H_NUM,
    PH_M_SKIP,
    PH_M_NUM,
    PH_PIX,
    PH_PIX_NUM,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [1:0] {
    RK_HEADER,
    RK_PIXEL,
    RK_ERROR
  } result_kind_e;

  typedef enum logic [1:0] {
    FMT_P2,
    FMT_P3,
    FMT_P5,
    FMT_P6
  } format_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_MAGIC,
    ERR_DIGIT,
    ERR_RANGE
  } error_code_e;

  // Channel index of the last channel in a pixel.
  localparam logic [1:0] CH_LAST_GRAY  = 2'd0;
  localparam logic [1:0] CH_LAST_COLOR = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } nps_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  pixel_value;
    logic [15:0] pixel_row;
    logic [15:0] pixel_column;
    logic [1:0]  color_channel;
    logic        is_last;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_value;
    logic [1:0]  pixel_format;
    logic [1:0]  error_code;
  } nps_out_t;

endpackage

// File: sv/nps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Netpbm stream parser channels
// Valid/ready channels for file bytes in and parse results out.
// ----------------------------------------------------------------------------
interface nps_in_if;
  import nps_pkg::*;

  logic    valid;
  logic    ready;
  nps_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface nps_out_if;
  import nps_pkg::*;

  logic     valid;
  logic     ready;
  nps_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: sv/nps_dec_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal accumulator step
// Appends one decimal digit to a running number, with saturation for text
// samples and an overflow flag for header numbers.
// ----------------------------------------------------------------------------
module nps_dec_acc (
  input  nps_pkg::dim_t acc_i,
  input  logic [3:0]    digit_i,
  input  logic          saturate_i,
  output nps_pkg::dim_t value_o,
  output logic          overflow_o
);
  import nps_pkg::*;

  acc_t acc_ext;
  acc_t step;

  // Multiply by ten as two shifts, then add the digit.
  always_comb begin
    acc_ext = acc_t'(acc_i);
    step    = (acc_ext << 3) + (acc_ext << 1) + acc_t'(digit_i);
  end

  // Text samples clamp at 255; header numbers flag values past the range.
  always_comb begin
    if (saturate_i) begin
      value_o    = (step > SAMPLE_MAX) ? dim_t'(SAMPLE_MAX) : step[DIM_BITS-1:0];
      overflow_o = 1'b0;
    end else begin
      value_o    = step[DIM_BITS-1:0];
      overflow_o = (step > DIM_MAX);
    end
  end

endmodule

// File: sv/netpbm_stream_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Netpbm stream parser core
// Parses a PGM/PPM file (P2, P3, P5, P6) byte by byte into a header result
// followed by one result per pixel sample, or an error result.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload                          | Per transaction
//  in_i    | sink      | data_byte, start_of_file         | one file byte
//  out_o   | source    | kind, pixel fields, header, err  | zero or one result
//
// A byte is taken whenever in_i.ready is high; the parse state updates at the same edge
// and any result lands in the output register, so bytes flow back to back while
// the output register is empty or its result is being taken.
// A stall on out_o holds the output register and stops input only while a
// result waits there untaken. Reset clears the parse state and all header
// values; start_of_file does the same for a new file.
// ----------------------------------------------------------------------------
module netpbm_stream_parser_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  nps_in_if.sink    in_i,
  nps_out_if.source out_o
);
  import nps_pkg::*;

  // Parse state.
  phase_e     phase_q, phase_d;
  logic [1:0] fmt_q, fmt_d;
  logic       comment_q, comment_d;
  dim_t       acc_q, acc_d;
  dim_t       width_q, width_d;
  dim_t       height_q, height_d;
  dim_t       maxval_q, maxval_d;
  dim_t       row_q, row_d;
  dim_t       col_q, col_d;
  logic [1:0] ch_q, ch_d;

  // Output register.
  logic     out_valid_q;
  nps_out_t out_q;

  logic     accept;
  logic [7:0] b;
  logic     sof;
  logic     digit, space, eol;
  logic     magic_ok;
  logic [1:0] magic_fmt;
  logic     raw_pix;
  logic     skip_phase;
  logic     num_phase;
  logic     text_phase;
  logic     eat_comment;
  logic     proceed;
  dim_t     step_value;
  logic     step_ovf;

  // Pixel bookkeeping.
  logic       pix_last;
  logic [1:0] ch_last_idx;
  dim_t       col_inc;

  logic     res_fire;
  nps_out_t res;

  assign accept    = in_i.valid & in_i.ready;
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign b         = in_i.payload.data_byte;
  assign sof       = in_i.payload.start_of_file;

  // Byte classes.
  always_comb begin
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    eol   = (b == CH_LF) || (b == CH_CR);
    space = (b == CH_SPACE) || (b == CH_TAB) || eol;
  end

  // Magic byte decode.
  always_comb begin
    magic_ok  = 1'b1;
    magic_fmt = FMT_P2;
    case (b)
      CH_TWO:   magic_fmt = FMT_P2;
      CH_THREE: magic_fmt = FMT_P3;
      CH_FIVE:  magic_fmt = FMT_P5;
      CH_SIX:   magic_fmt = FMT_P6;
      default:  magic_ok = 1'b0;
    endcase
  end

  // Phase classes and comment handling.
  always_comb begin
    raw_pix    = (phase_q == PH_PIX) && fmt_q[1];
    skip_phase = (phase_q == PH_W_SKIP) || (phase_q == PH_H_SKIP) ||
                 (phase_q == PH_M_SKIP) || (phase_q == PH_PIX);
    num_phase  = (phase_q == PH_W_NUM) || (phase_q == PH_H_NUM) ||
                 (phase_q == PH_M_NUM) || (phase_q == PH_PIX_NUM);
    text_phase = (skip_phase || num_phase) && !raw_pix;
    eat_comment = comment_q ? !eol : (b == CH_HASH);
    proceed    = text_phase && !eat_comment;
  end

  nps_dec_acc u_dec_acc (
    .acc_i      (acc_q),
    .digit_i    (b[3:0]),
    .saturate_i (phase_q == PH_PIX_NUM),
    .value_o    (step_value),
    .overflow_o (step_ovf)
  );

  // Position of the current sample within the image.
  always_comb begin
    ch_last_idx = fmt_q[0] ? CH_LAST_COLOR : CH_LAST_GRAY;
    col_inc     = col_q + dim_t'(1);
    pix_last    = (ch_q == ch_last_idx) &&
                  (({1'b0, col_q} + {{DIM_BITS{1'b0}}, 1'b1}) == {1'b0, width_q}) &&
                  (({1'b0, row_q} + {{DIM_BITS{1'b0}}, 1'b1}) == {1'b0, height_q});
  end

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    fmt_d     = fmt_q;
    comment_d = comment_q;
    acc_d     = acc_q;
    width_d   = width_q;
    height_d  = height_q;
    maxval_d  = maxval_q;
    row_d     = row_q;
    col_d     = col_q;
    ch_d      = ch_q;
    if (accept) begin
      if (sof) begin
        phase_d   = PH_MAGIC1;
        fmt_d     = FMT_P2;
        comment_d = 1'b0;
        acc_d     = '0;
        width_d   = '0;
        height_d  = '0;
        maxval_d  = '0;
        row_d     = '0;
        col_d     = '0;
        ch_d      = '0;
      end else begin
        case (phase_q)
          PH_MAGIC0: begin
            phase_d = PH_MAGIC1;
          end
          PH_MAGIC1: begin
            if (magic_ok) begin
              fmt_d   = magic_fmt;
              phase_d = PH_W_SKIP;
            end else begin
              phase_d   = PH_ERROR;
              comment_d = 1'b0;
            end
          end
          PH_DONE, PH_ERROR: begin
          end
          default: begin
            if (!raw_pix && comment_q && eat_comment) begin
              // Inside a comment: drop the byte.
            end else if (!raw_pix && eat_comment) begin
              comment_d = 1'b1;
            end else begin
              comment_d = 1'b0;
              if (!raw_pix && skip_phase) begin
                if (!space && !digit) begin
                  phase_d = PH_ERROR;
                end else if (digit) begin
                  acc_d   = dim_t'(b[3:0]);
                  phase_d = phase_e'(phase_q + 4'd1);
                end
              end else if (!raw_pix && digit) begin
                if (step_ovf) begin
                  phase_d = PH_ERROR;
                end else begin
                  acc_d = step_value;
                end
              end else if (phase_q == PH_W_NUM) begin
                width_d = acc_q;
                phase_d = PH_H_SKIP;
              end else if (phase_q == PH_H_NUM) begin
                height_d = acc_q;
                phase_d  = PH_M_SKIP;
              end else if (phase_q == PH_M_NUM) begin
                maxval_d = acc_q;
                row_d    = '0;
                col_d    = '0;
                ch_d     = '0;
                phase_d  = ((width_q == '0) || (height_q == '0)) ? PH_DONE : PH_PIX;
              end else begin
                // Raw byte or the end of a text sample: one pixel sample.
                phase_d = pix_last ? PH_DONE : PH_PIX;
                if (ch_q == ch_last_idx) begin
                  ch_d = '0;
                  if (col_inc >= width_q) begin
                    col_d = '0;
                    row_d = row_q + dim_t'(1);
                  end else begin
                    col_d = col_inc;
                  end
                end else begin
                  ch_d = ch_q + 2'd1;
                end
              end
            end
          end
        endcase
      end
    end
  end

  // Result produced by this byte.
  always_comb begin
    res_fire           = 1'b0;
    res.result_kind    = RK_HEADER;
    res.pixel_value    = '0;
    res.pixel_row      = '0;
    res.pixel_column   = '0;
    res.color_channel  = '0;
    res.is_last        = 1'b0;
    res.image_width    = 16'(width_q);
    res.image_height   = 16'(height_q);
    res.max_value      = 16'(maxval_q);
    res.pixel_format   = fmt_q;
    res.error_code     = ERR_NONE;
    if (!sof) begin
      if (phase_q == PH_MAGIC1 && !magic_ok) begin
        res_fire        = 1'b1;
        res.result_kind = RK_ERROR;
        res.error_code  = ERR_MAGIC;
      end else if (raw_pix || (proceed && num_phase && !digit)) begin
        res_fire = 1'b1;
        if (phase_q == PH_M_NUM) begin
          res.result_kind = RK_HEADER;
          res.max_value   = 16'(acc_q);
        end else if (phase_q == PH_W_NUM || phase_q == PH_H_NUM) begin
          res_fire = 1'b0;
        end else begin
          res.result_kind   = RK_PIXEL;
          res.pixel_value   = raw_pix ? b : acc_q[7:0];
          res.pixel_row     = 16'(row_q);
          res.pixel_column  = 16'(col_q);
          res.color_channel = ch_q;
          res.is_last       = pix_last;
        end
      end else if (proceed && skip_phase && !space && !digit) begin
        res_fire        = 1'b1;
        res.result_kind = RK_ERROR;
        res.error_code  = ERR_DIGIT;
      end else if (proceed && num_phase && digit && step_ovf) begin
        res_fire        = 1'b1;
        res.result_kind = RK_ERROR;
        res.error_code  = ERR_RANGE;
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC0;
      fmt_q     <= FMT_P2;
      comment_q <= 1'b0;
      acc_q     <= '0;
      width_q   <= '0;
      height_q  <= '0;
      maxval_q  <= '0;
      row_q     <= '0;
      col_q     <= '0;
      ch_q      <= '0;
    end else begin
      phase_q   <= phase_d;
      fmt_q     <= fmt_d;
      comment_q <= comment_d;
      acc_q     <= acc_d;
      width_q   <= width_d;
      height_q  <= height_d;
      maxval_q  <= maxval_d;
      row_q     <= row_d;
      col_q     <= col_d;
      ch_q      <= ch_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= accept & res_fire;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && accept && res_fire) begin
      out_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

// File: tb/sv/netpbm_stream_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Netpbm stream parser core testbench
// Feeds PGM/PPM byte streams through the valid/ready input channel and
// checks every header, pixel and error result against a cycle-free image
// parser kept inside this module. Directed files hit the error codes and the
// format corner cases. Random files in all four formats follow, some broken
// or cut short, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module netpbm_stream_parser_core_tb;
  import nps_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1200;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned MAX_SAMPLES  = 40;

  logic clk_i;
  logic rst_ni;

  nps_in_if  in_ch ();
  nps_out_if out_ch ();

  netpbm_stream_parser_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Image parser state, updated once per accepted file byte.
  phase_e      st_phase;
  format_e     st_format;
  logic        st_comment;
  int unsigned st_number;
  dim_t        hdr_width;
  dim_t        hdr_height;
  dim_t        hdr_maxval;
  dim_t        pos_row;
  dim_t        pos_col;
  logic [1:0]  pos_chan;

  nps_out_t    expected_results[$];
  logic [7:0]  file_bytes[$];

  bit          feed_gaps_on;
  bit          sink_stalls_on;
  int unsigned bytes_sent;
  int unsigned files_sent;
  int unsigned pauses;
  int unsigned headers_seen;
  int unsigned pixels_seen;
  int unsigned errors_seen;
  int unsigned failures;
  int unsigned cycle_count = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("netpbm_stream_parser_core test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Image parser
  // --------------------------------------------------------------------------

  // Clears the parse state, as reset and a new file do.
  function automatic void clear_parser();
    st_phase   = PH_MAGIC0;
    st_format  = FMT_P2;
    st_comment = 1'b0;
    st_number  = 0;
    hdr_width  = '0;
    hdr_height = '0;
    hdr_maxval = '0;
    pos_row    = '0;
    pos_col    = '0;
    pos_chan   = '0;
  endfunction

  // Builds a result; the header fields always reflect what was parsed so far.
  function automatic nps_out_t pack_result(result_kind_e kind, logic [7:0] value,
                                           dim_t row, dim_t col, logic [1:0] chan,
                                           logic last, error_code_e err);
    nps_out_t r;
    r.result_kind   = kind;
    r.pixel_value   = value;
    r.pixel_row     = row;
    r.pixel_column  = col;
    r.color_channel = chan;
    r.is_last       = last;
    r.image_width   = hdr_width;
    r.image_height  = hdr_height;
    r.max_value     = hdr_maxval;
    r.pixel_format  = st_format;
    r.error_code    = err;
    return r;
  endfunction

  function automatic nps_out_t raise_error(error_code_e err);
    st_phase   = PH_ERROR;
    st_comment = 1'b0;
    return pack_result(RK_ERROR, '0, '0, '0, '0, 1'b0, err);
  endfunction

  // Emits one sample and steps channel, column and row.
  function automatic nps_out_t emit_sample(logic [7:0] value);
    logic [1:0] chan_last;
    logic       last;
    nps_out_t   r;
    chan_last = st_format[0] ? CH_LAST_COLOR : CH_LAST_GRAY;
    last = (32'(pos_row) + 1 == 32'(hdr_height)) &&
           (32'(pos_col) + 1 == 32'(hdr_width)) && (pos_chan == chan_last);
    r = pack_result(RK_PIXEL, value, pos_row, pos_col, pos_chan, last, ERR_NONE);
    if (pos_chan == chan_last) begin
      pos_chan = '0;
      pos_col  = pos_col + 1'b1;
      if (pos_col >= hdr_width) begin
        pos_col = '0;
        pos_row = pos_row + 1'b1;
      end
    end else begin
      pos_chan = pos_chan + 1'b1;
    end
    if (last) st_phase = PH_DONE;
    return r;
  endfunction

  // Consumes one file byte; returns 1 when the byte produces a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic sof,
                                    output nps_out_t res);
    bit          is_digit;
    bit          is_space;
    int unsigned digit;
    int unsigned num;
    res = '0;
    if (sof) begin
      clear_parser();
      st_phase = PH_MAGIC1;
      return 0;
    end
    case (st_phase)
      PH_MAGIC0: begin
        st_phase = PH_MAGIC1;
        return 0;
      end
      PH_MAGIC1: begin
        case (b)
          CH_TWO:   st_format = FMT_P2;
          CH_THREE: st_format = FMT_P3;
          CH_FIVE:  st_format = FMT_P5;
          CH_SIX:   st_format = FMT_P6;
          default: begin
            res = raise_error(ERR_MAGIC);
            return 1;
          end
        endcase
        st_phase = PH_W_SKIP;
        return 0;
      end
      PH_DONE, PH_ERROR: return 0;
      default: ;
    endcase

    // Raw formats take every byte as a sample.
    if (st_phase == PH_PIX && st_format[1]) begin
      res = emit_sample(b);
      return 1;
    end

    // A comment runs to the line end, which then acts as whitespace.
    if (st_comment) begin
      if (b != CH_LF && b != CH_CR) return 0;
      st_comment = 1'b0;
    end else if (b == CH_HASH) begin
      st_comment = 1'b1;
      return 0;
    end

    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    digit    = is_digit ? (b - CH_ZERO) : 0;

    // Waiting for the first digit of a number.
    if (st_phase inside {PH_W_SKIP, PH_H_SKIP, PH_M_SKIP, PH_PIX}) begin
      if (is_space) return 0;
      if (!is_digit) begin
        res = raise_error(ERR_DIGIT);
        return 1;
      end
      st_number = digit;
      st_phase  = phase_e'(st_phase + 1);
      return 0;
    end

    // Further digits: samples saturate, header numbers must fit.
    if (is_digit) begin
      num = st_number * 10 + digit;
      if (st_phase == PH_PIX_NUM) begin
        if (num > 255) num = 255;
      end else if (num > DIM_MAX) begin
        res = raise_error(ERR_RANGE);
        return 1;
      end
      st_number = num;
      return 0;
    end

    // Any other byte ends the number.
    case (st_phase)
      PH_W_NUM: begin
        hdr_width = dim_t'(st_number);
        st_phase  = PH_H_SKIP;
        return 0;
      end
      PH_H_NUM: begin
        hdr_height = dim_t'(st_number);
        st_phase   = PH_M_SKIP;
        return 0;
      end
      PH_M_NUM: begin
        hdr_maxval = dim_t'(st_number);
        pos_row    = '0;
        pos_col    = '0;
        pos_chan   = '0;
        st_phase   = (hdr_width == '0 || hdr_height == '0) ? PH_DONE : PH_PIX;
        res = pack_result(RK_HEADER, '0, '0, '0, '0, 1'b0, ERR_NONE);
        return 1;
      end
      default: begin
        st_phase = PH_PIX;
        res = emit_sample(8'(st_number));
        return 1;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic void report_failure(string msg);
    failures++;
    if (failures <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      report_failure($sformatf("%s expected %0h, got %0h", name, want, got));
    end
  endfunction

  function automatic void check_result(nps_out_t got);
    nps_out_t want;
    if (expected_results.size() == 0) begin
      report_failure($sformatf("result %h arrived with none expected", got));
      return;
    end
    want = expected_results.pop_front();
    if (want.result_kind == RK_HEADER) headers_seen++;
    else if (want.result_kind == RK_PIXEL) pixels_seen++;
    else errors_seen++;
    compare_field("result_kind", want.result_kind, got.result_kind);
    compare_field("pixel_value", want.pixel_value, got.pixel_value);
    compare_field("pixel_row", want.pixel_row, got.pixel_row);
    compare_field("pixel_column", want.pixel_column, got.pixel_column);
    compare_field("color_channel", want.color_channel, got.color_channel);
    compare_field("is_last", want.is_last, got.is_last);
    compare_field("image_width", want.image_width, got.image_width);
    compare_field("image_height", want.image_height, got.image_height);
    compare_field("max_value", want.max_value, got.max_value);
    compare_field("pixel_format", want.pixel_format, got.pixel_format);
    compare_field("error_code", want.error_code, got.error_code);
  endfunction

  // Result sink: random stall before each transaction, then check it.
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = sink_stalls_on ? $urandom_range(0, 17) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      check_result(out_ch.payload);
    end
  end

  // --------------------------------------------------------------------------
  // Byte source
  // --------------------------------------------------------------------------

  // Sends one byte after a random gap and predicts its result on acceptance.
  task automatic send_byte(input logic [7:0] data, input logic sof);
    int unsigned gap;
    nps_in_t     item;
    nps_out_t    outcome;
    gap = feed_gaps_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.data_byte     = data;
    item.start_of_file = sof;
    in_ch.valid   <= 1'b1;
    in_ch.payload <= item;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
    if (parse_byte(data, sof, outcome)) expected_results.push_back(outcome);
  endtask

  task automatic send_text(input string s, input logic sof_first);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], sof_first && (i == 0));
    end
  endtask

  // Holds the source off until every outstanding result has been taken.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    pauses++;
  endtask

  // --------------------------------------------------------------------------
  // Random file building
  // --------------------------------------------------------------------------

  function automatic void put_number(int unsigned v);
    string digits;
    if ($urandom_range(0, 7) == 0) file_bytes.push_back(CH_ZERO);
    digits = $sformatf("%0d", v);
    for (int i = 0; i < digits.len(); i++) file_bytes.push_back(digits[i]);
  endfunction

  // Header number, now and then one that does not fit in 16 bits.
  function automatic void put_field(int unsigned v);
    put_number(($urandom_range(0, 29) == 0) ? $urandom_range(65536, 999999) : v);
  endfunction

  // Whitespace and comments; a single element where exactly one byte of
  // separation counts, as after maxval in raw files.
  function automatic void put_sep(bit single);
    int unsigned n;
    logic [7:0]  c;
    n = single ? 1 : $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: file_bytes.push_back(CH_TAB);
        1: file_bytes.push_back(CH_LF);
        2: file_bytes.push_back(CH_CR);
        3: begin
          file_bytes.push_back(CH_HASH);
          repeat ($urandom_range(0, 4)) begin
            do c = 8'($urandom); while (c == CH_LF || c == CH_CR);
            file_bytes.push_back(c);
          end
          file_bytes.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
        end
        default: file_bytes.push_back(CH_SPACE);
      endcase
    end
  endfunction

  function automatic int unsigned pick_dim(int unsigned typical_max);
    case ($urandom_range(0, 19))
      0, 1:    return 0;
      2:       return $urandom_range(5, 65535);
      default: return $urandom_range(1, typical_max);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Right after reset the first byte is dropped even without start_of_file;
  // a bad format code then locks out the rest of the file.
  task automatic test_bad_magic();
    feed_gaps_on   = 1'b0;
    sink_stalls_on = 1'b0;
    send_text("P75", 1'b0);
    drain_results();
  endtask

  // Raw gray with tab and CR separators, samples at both byte extremes, one
  // above maxval, and a byte after the last pixel that must be ignored.
  task automatic test_raw_gray();
    send_text("P5 2\t1\015", 1'b1);
    send_text("9\n", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CH_HASH, 1'b0);
    drain_results();
  endtask

  // Text color with comments, a saturating sample and a sample ended by the
  // line end of a comment.
  task automatic test_text_color();
    feed_gaps_on   = 1'b1;
    sink_stalls_on = 1'b1;
    send_text("P3#\n1 1 9 300 5#\n7\n", 1'b1);
    drain_results();
  endtask

  // Non-digit at a number start, header overflow, zero width, and a file
  // that stops in the middle of a text sample.
  task automatic test_header_errors();
    feed_gaps_on   = 1'b0;
    sink_stalls_on = 1'b1;
    send_text("P2 x", 1'b1);
    send_text("P6 65536", 1'b1);
    send_text("P2 0 5 1 7 ", 1'b1);
    send_text("P2 2 1 9 4 3", 1'b1);
    drain_results();
  endtask

  // Mostly well-formed files with random content; some get a stray byte,
  // a bad magic, an oversized number or are cut short. Bursts of noise and
  // pauses until all results are in are mixed in.
  task automatic test_random_files();
    int unsigned start_count;
    int unsigned w;
    int unsigned h;
    int unsigned samples;
    logic [7:0]  magic;
    bit          is_text;
    bit          is_color;
    bit          sof;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      feed_gaps_on   = $urandom_range(0, 3) != 0;
      sink_stalls_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) == 0) begin
        // Noise burst.
        repeat ($urandom_range(3, 12)) begin
          send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
      end else begin
        file_bytes.delete();
        file_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h50);
        case ($urandom_range(0, 12))
          0:       magic = 8'($urandom);
          1, 2, 3: magic = CH_TWO;
          4, 5, 6: magic = CH_THREE;
          7, 8, 9: magic = CH_FIVE;
          default: magic = CH_SIX;
        endcase
        file_bytes.push_back(magic);
        is_text  = (magic == CH_TWO) || (magic == CH_THREE);
        is_color = (magic == CH_THREE) || (magic == CH_SIX);
        if ($urandom_range(0, 1)) put_sep(1'b0);

        // Header.
        w = pick_dim(4);
        h = pick_dim(3);
        put_field(w);
        put_sep(1'b0);
        put_field(h);
        put_sep(1'b0);
        put_field($urandom_range(0, 1) ? 255 : $urandom_range(0, 65535));
        put_sep(!is_text);

        // Samples, capped so that huge images end early.
        if (w > MAX_SAMPLES || h > MAX_SAMPLES) samples = MAX_SAMPLES;
        else samples = w * h * (is_color ? 3 : 1);
        if (samples > MAX_SAMPLES) samples = MAX_SAMPLES;
        if ($urandom_range(0, 9) == 0) samples = $urandom_range(0, samples);
        for (int i = 0; i < samples; i++) begin
          if (is_text) begin
            put_number(($urandom_range(0, 3) == 0) ? $urandom_range(256, 999)
                                                   : $urandom_range(0, 255));
            if (i + 1 < samples || $urandom_range(0, 7) != 0) put_sep(1'b0);
          end else begin
            file_bytes.push_back(8'($urandom));
          end
        end

        // Occasional stray byte inside, or trailing bytes after the image.
        if ($urandom_range(0, 7) == 0) begin
          file_bytes.insert($urandom_range(1, file_bytes.size() - 1), 8'($urandom));
        end
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
        end

        sof = $urandom_range(0, 9) != 0;
        foreach (file_bytes[i]) send_byte(file_bytes[i], sof && (i == 0));
        files_sent++;
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    feed_gaps_on   = 1'b0;
    sink_stalls_on = 1'b0;
    bytes_sent     = 0;
    files_sent     = 0;
    pauses         = 0;
    headers_seen   = 0;
    pixels_seen    = 0;
    errors_seen    = 0;
    failures       = 0;
    clear_parser();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bad_magic();
    test_raw_gray();
    test_text_color();
    test_header_errors();
    test_random_files();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", expected_results.size()));
    end

    $display("Sent %0d bytes in %0d random files plus directed P2/P3/P5/P6 cases, %0d pauses.",
             bytes_sent, files_sent, pauses);
    $display("Checked %0d headers, %0d pixels and %0d errors; %0d mismatches.",
             headers_seen, pixels_seen, errors_seen, failures);
    if (failures == 0) begin
      $display("netpbm_stream_parser_core test passed");
    end else begin
      $display("netpbm_stream_parser_core test failed");
    end
    $finish;
  end

endmodule

// File: netpbm_stream_parser_core.f
sv/nps_pkg.sv
sv/nps_if.sv
sv/nps_dec_acc.sv
sv/netpbm_stream_parser_core.sv
tb/sv/netpbm_stream_parser_core_tb.sv
